[design/bged_pkg.sv]
// ============================================================================
// bged_pkg
// Shared types and constants of the button gesture event detector: word
// layouts, chain link between button cells, event kind codes.
// ============================================================================
package bged_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int TIME_WIDTH  = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int KINDS       = 4;
    localparam int INDEX_WIDTH = 3;
    localparam int KIND_WIDTH  = 2;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd500;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    // Event kind codes
    localparam logic [KIND_WIDTH-1:0] EV_TOUCH   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] EV_TAP     = 2'd1;
    localparam logic [KIND_WIDTH-1:0] EV_HOLD    = 2'd2;
    localparam logic [KIND_WIDTH-1:0] EV_RELEASE = 2'd3;

    // Input word: one poll
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_levels;
        logic [TIME_WIDTH-1:0]  now_ms;
    } bged_in_t;

    // Output word: one reported event
    typedef struct packed {
        logic                   event_valid;
        logic [INDEX_WIDTH-1:0] button_index;
        logic [KIND_WIDTH-1:0]  event_kind;
    } bged_out_t;

    // Link between neighboring cells: the event picked so far
    typedef struct packed {
        logic                   found;
        logic [INDEX_WIDTH-1:0] button_index;
        logic [KIND_WIDTH-1:0]  event_kind;
    } bged_chain_t;

endpackage

[design/button_gesture_event_detector_unit.sv]
// ============================================================================
// button_gesture_event_detector_unit
// Debounced tap/touch/hold/release detector for a row of buttons. One cell
// per button; the cells pass the event pick down the row, lowest button first.
// ============================================================================
//
//  channel | signals                          | word
//  --------+----------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_data      | raw_levels, now_ms
//  out     | out_valid, out_ready, out_data   | event_valid, button_index,
//          |                                  | event_kind
//  cfg     | cfg_write_en, cfg_index, cfg_data| 0 debounce_ms, 1 hold_timeout_ms
//
//  One input word per cycle while the output register can take it; its
//  result word is registered at acceptance. Each poll yields one result word.
//  The output register is the only stage: in_ready is high while it is
//  empty or being drained, so a stalled consumer stalls input by one word.
//  Reset clears all button state, and loads debounce 50 and hold 500.
//
module button_gesture_event_detector_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bged_pkg::bged_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bged_pkg::bged_out_t                out_data,
    input  logic                               cfg_write_en,
    input  logic                               cfg_index,
    input  logic [bged_pkg::CFG_WIDTH-1:0]     cfg_data
);

    logic [bged_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [bged_pkg::CFG_WIDTH-1:0] hold_reg;
    logic                           out_valid_reg;
    bged_pkg::bged_out_t            out_reg, out_next;
    logic                           advance;
    bged_pkg::bged_chain_t          chain [0:bged_pkg::NUM_BUTTONS];

    // Handshake
    assign in_ready  = !out_valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= bged_pkg::DEBOUNCE_RESET;
            hold_reg     <= bged_pkg::HOLD_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bged_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                bged_pkg::CFG_HOLD:     hold_reg     <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Row of button cells
    assign chain[0] = '0;

    for (genvar b = 0; b < bged_pkg::NUM_BUTTONS; b++)
    begin : g_cell
        bged_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .cell_index      (bged_pkg::INDEX_WIDTH'(b)),
            .raw             (in_data.raw_levels[b]),
            .now_ms          (in_data.now_ms),
            .debounce_ms     (debounce_reg),
            .hold_timeout_ms (hold_reg),
            .chain_in        (chain[b]),
            .chain_out       (chain[b+1])
        );
    end

    // Result word; zeros when no event
    always_comb
    begin
        out_next.event_valid  = chain[bged_pkg::NUM_BUTTONS].found;
        out_next.button_index = chain[bged_pkg::NUM_BUTTONS].button_index;
        out_next.event_kind   = chain[bged_pkg::NUM_BUTTONS].event_kind;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Checks
    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("accepted poll produced no result word");

    a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.event_valid) |->
            (out_data.button_index == '0 && out_data.event_kind == '0))
        else $error("empty result word carries nonzero fields");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.event_valid) |->
            (out_data.button_index < bged_pkg::INDEX_WIDTH'(bged_pkg::NUM_BUTTONS)))
        else $error("event reported for a button that does not exist");

endmodule

[design/bged_cell.sv]
// ============================================================================
// bged_cell
// One button: debounce, press/release edges, hold timer and four pending
// event flags. Takes the pick from its upstream neighbor and passes it on,
// inserting its own lowest event when nothing upstream was found.
// ============================================================================
module bged_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic [bged_pkg::INDEX_WIDTH-1:0]       cell_index,
    input  logic                                   raw,
    input  logic [bged_pkg::TIME_WIDTH-1:0]        now_ms,
    input  logic [bged_pkg::CFG_WIDTH-1:0]         debounce_ms,
    input  logic [bged_pkg::CFG_WIDTH-1:0]         hold_timeout_ms,
    input  bged_pkg::bged_chain_t                  chain_in,
    output bged_pkg::bged_chain_t                  chain_out
);

    logic                                stable_reg, stable_next;
    logic                                last_raw_reg;
    logic [bged_pkg::TIME_WIDTH-1:0]     change_time_reg, change_time_next;
    logic [bged_pkg::TIME_WIDTH-1:0]     press_time_reg, press_time_next;
    logic                                armed_reg, armed_next;
    logic [bged_pkg::KINDS-1:0]          pend_reg, pend_next;

    logic                                raw_diff;
    logic [bged_pkg::TIME_WIDTH-1:0]     deb_elapsed;
    logic [bged_pkg::TIME_WIDTH-1:0]     hold_elapsed;
    logic                                take_level;
    logic                                press;
    logic                                release_edge;
    logic                                hold_fire;
    logic [bged_pkg::KINDS-1:0]          raised;
    logic [bged_pkg::KIND_WIDTH-1:0]     low_kind;
    logic                                emit;

    // Debounce: accept a raw level once stable long enough
    assign raw_diff    = (raw != last_raw_reg);
    assign deb_elapsed = now_ms - change_time_reg;
    assign take_level  = !raw_diff && (raw != stable_reg) &&
                         (deb_elapsed >= {{(bged_pkg::TIME_WIDTH-bged_pkg::CFG_WIDTH){1'b0}},
                                          debounce_ms});
    assign stable_next      = take_level ? raw : stable_reg;
    assign change_time_next = (raw_diff || take_level) ? now_ms : change_time_reg;

    // Stable edges; active low, so a new 0 is a press
    assign press        = take_level && !raw;
    assign release_edge = take_level && raw;

    // Hold timer; an edge in this poll never fires it
    assign hold_elapsed = now_ms - press_time_reg;
    assign hold_fire    = armed_reg && !take_level &&
                          (hold_elapsed > {{(bged_pkg::TIME_WIDTH-bged_pkg::CFG_WIDTH){1'b0}},
                                           hold_timeout_ms});
    assign press_time_next = press ? now_ms : press_time_reg;

    always_comb
    begin
        armed_next = armed_reg;
        if (press)
        begin
            armed_next = 1'b1;
        end
        else if (release_edge || hold_fire)
        begin
            armed_next = 1'b0;
        end
    end

    // Newly raised events merged with the pending ones
    always_comb
    begin
        raised = pend_reg;
        raised[bged_pkg::EV_TOUCH]   = pend_reg[bged_pkg::EV_TOUCH] | press;
        raised[bged_pkg::EV_TAP]     = pend_reg[bged_pkg::EV_TAP] | (release_edge && armed_reg);
        raised[bged_pkg::EV_HOLD]    = pend_reg[bged_pkg::EV_HOLD] | hold_fire;
        raised[bged_pkg::EV_RELEASE] = pend_reg[bged_pkg::EV_RELEASE] | release_edge;
    end

    // Lowest pending kind of this button
    always_comb
    begin
        low_kind = '0;
        for (int k = bged_pkg::KINDS - 1; k >= 0; k--)
        begin
            if (raised[k])
            begin
                low_kind = bged_pkg::KIND_WIDTH'(k);
            end
        end
    end

    // Pick goes to this cell only when nothing upstream was found
    assign emit = !chain_in.found && (|raised);

    always_comb
    begin
        pend_next = raised;
        if (emit)
        begin
            pend_next[low_kind] = 1'b0;
        end
    end

    always_comb
    begin
        chain_out = chain_in;
        if (emit)
        begin
            chain_out.found        = 1'b1;
            chain_out.button_index = cell_index;
            chain_out.event_kind   = low_kind;
        end
    end

    // Button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b1;
            last_raw_reg    <= 1'b1;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            armed_reg       <= 1'b0;
            pend_reg        <= '0;
        end
        else if (advance)
        begin
            stable_reg      <= stable_next;
            last_raw_reg    <= raw;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            armed_reg       <= armed_next;
            pend_reg        <= pend_next;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the button gesture event detector. Polls go in as
// valid/ready words, each one is run through a behavioral tracker of the
// debounce and gesture state here, and every result word is checked against
// the oldest predicted event. Directed polls hit the timing boundaries and
// counter wrap, then random button activity runs under several timing
// settings with sender gaps, consumer stalls and one long consumer hold-off.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    bged_pkg::bged_in_t             in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    bged_pkg::bged_out_t            out_data;
    logic                           cfg_write_en = 1'b0;
    logic                           cfg_index = bged_pkg::CFG_DEBOUNCE;
    logic [bged_pkg::CFG_WIDTH-1:0] cfg_data = '0;

    // Gesture tracker state
    logic [bged_pkg::CFG_WIDTH-1:0]   debounce_set = bged_pkg::DEBOUNCE_RESET;
    logic [bged_pkg::CFG_WIDTH-1:0]   hold_set     = bged_pkg::HOLD_RESET;
    logic [bged_pkg::NUM_BUTTONS-1:0] settled_level;
    logic [bged_pkg::NUM_BUTTONS-1:0] seen_level;
    logic [bged_pkg::NUM_BUTTONS-1:0] hold_armed;
    logic [bged_pkg::TIME_WIDTH-1:0]  change_ts [bged_pkg::NUM_BUTTONS];
    logic [bged_pkg::TIME_WIDTH-1:0]  press_ts  [bged_pkg::NUM_BUTTONS];
    logic [bged_pkg::KINDS-1:0]       pending_kinds [bged_pkg::NUM_BUTTONS];

    bged_pkg::bged_out_t expected_events [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;
    int hold_off_ack   = 0;
    int hold_off_left  = 0;

    button_gesture_event_detector_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Long consumer hold-off, counted here once requested
    always @(posedge clk)
    begin
        if (hold_off_req != hold_off_ack)
        begin
            hold_off_ack  <= hold_off_req;
            hold_off_left <= HOLD_OFF_CYCLES;
        end
        else if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
    end

    // Result check, then next consumer ready
    always @(posedge clk)
    begin : result_check
        bged_pkg::bged_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected event word: valid=%0d button=%0d kind=%0d",
                             out_data.event_valid, out_data.button_index,
                             out_data.event_kind);
            end
            else
            begin
                want = expected_events.pop_front();
                if (out_data.event_valid !== want.event_valid ||
                    out_data.button_index !== want.button_index ||
                    out_data.event_kind !== want.event_kind)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: exp v=%0d b=%0d k=%0d, got v=%0d b=%0d k=%0d",
                                 want.event_valid, want.button_index, want.event_kind,
                                 out_data.event_valid, out_data.button_index,
                                 out_data.event_kind);
                end
            end
        end
        out_ready <= (hold_off_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Debounce and gesture tracking for one accepted poll; queues its event
    task automatic predict_gesture_event(input logic [bged_pkg::NUM_BUTTONS-1:0] raw,
                                         input logic [bged_pkg::TIME_WIDTH-1:0] now);
        logic [bged_pkg::TIME_WIDTH-1:0] since;
        logic                            was_level;
        logic                            found;
        bged_pkg::bged_out_t             picked;
        for (int b = 0; b < bged_pkg::NUM_BUTTONS; b++)
        begin
            was_level = settled_level[b];
            since     = now - change_ts[b];
            // raw edge restarts the stability window
            if (raw[b] != seen_level[b])
            begin
                seen_level[b] = raw[b];
                change_ts[b]  = now;
            end
            else if (since >= debounce_set && raw[b] != settled_level[b])
            begin
                settled_level[b] = raw[b];
                change_ts[b]     = now;
            end
            if (was_level && !settled_level[b])
            begin
                press_ts[b]                          = now;
                hold_armed[b]                        = 1'b1;
                pending_kinds[b][bged_pkg::EV_TOUCH] = 1'b1;
            end
            else if (!was_level && settled_level[b])
            begin
                // tap only if the hold never fired
                if (hold_armed[b])
                begin
                    hold_armed[b]                      = 1'b0;
                    pending_kinds[b][bged_pkg::EV_TAP] = 1'b1;
                end
                pending_kinds[b][bged_pkg::EV_RELEASE] = 1'b1;
            end
            since = now - press_ts[b];
            if (hold_armed[b] && since > hold_set)
            begin
                hold_armed[b]                       = 1'b0;
                pending_kinds[b][bged_pkg::EV_HOLD] = 1'b1;
            end
        end
        // lowest button first, then lowest kind
        picked = '0;
        found  = 1'b0;
        for (int b = 0; b < bged_pkg::NUM_BUTTONS; b++)
        begin
            for (int k = 0; k < bged_pkg::KINDS; k++)
            begin
                if (!found && pending_kinds[b][k])
                begin
                    found                = 1'b1;
                    pending_kinds[b][k]  = 1'b0;
                    picked.event_valid   = 1'b1;
                    picked.button_index  = bged_pkg::INDEX_WIDTH'(b);
                    picked.event_kind    = bged_pkg::KIND_WIDTH'(k);
                end
            end
        end
        expected_events.push_back(picked);
    endtask

    // Offer one poll word and hold it until accepted, then maybe go idle
    task automatic send_poll(input logic [bged_pkg::NUM_BUTTONS-1:0] raw,
                             input logic [bged_pkg::TIME_WIDTH-1:0] now);
        int gap;
        in_valid           <= 1'b1;
        in_data.raw_levels <= raw;
        in_data.now_ms     <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_gesture_event(raw, now);
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid after the last word of a stream
    task automatic finish_stream();
        if (in_valid)
            in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Both timing registers, written only with nothing in flight
    task automatic program_timing(input logic [bged_pkg::CFG_WIDTH-1:0] debounce,
                                  input logic [bged_pkg::CFG_WIDTH-1:0] hold);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= bged_pkg::CFG_DEBOUNCE;
        cfg_data     <= debounce;
        @(posedge clk);
        cfg_index    <= bged_pkg::CFG_HOLD;
        cfg_data     <= hold;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        debounce_set = debounce;
        hold_set     = hold;
        @(posedge clk);
    endtask

    // Random button activity: held levels that toggle now and then, single-poll
    // bounces, and a few polls of pure noise
    task automatic run_random_polls(input int count,
                                    input logic [bged_pkg::CFG_WIDTH-1:0] debounce,
                                    input logic [bged_pkg::CFG_WIDTH-1:0] hold,
                                    input int max_step,
                                    input logic [bged_pkg::TIME_WIDTH-1:0] start_ms,
                                    input int idle_pct,
                                    input int stall_pct);
        logic [bged_pkg::TIME_WIDTH-1:0]  clock_ms;
        logic [bged_pkg::NUM_BUTTONS-1:0] intended;
        logic [bged_pkg::NUM_BUTTONS-1:0] raw;
        program_timing(debounce, hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        clock_ms = start_ms;
        intended = bged_pkg::NUM_BUTTONS'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_poll(bged_pkg::NUM_BUTTONS'($urandom), $urandom);
            else
            begin
                for (int b = 0; b < bged_pkg::NUM_BUTTONS; b++)
                    if ($urandom_range(0, 99) < 6)
                        intended[b] = ~intended[b];
                raw = intended;
                if ($urandom_range(0, 99) < 5)
                    raw[$urandom_range(0, bged_pkg::NUM_BUTTONS - 1)] ^= 1'b1;
                clock_ms = clock_ms + $urandom_range(0, max_step);
                send_poll(raw, clock_ms);
            end
        end
        finish_stream();
    endtask

    // Boundaries of debounce and hold, every kind, several buttons, counter wrap
    task automatic test_directed_gestures();
        send_poll(5'b11111, 32'd0);
        send_poll(5'b01110, 32'd10);
        send_poll(5'b01110, 32'd60);           // debounce exactly met
        send_poll(5'b01110, 32'd560);          // hold exactly at timeout, no fire
        send_poll(5'b01110, 32'd561);          // hold fires
        send_poll(5'b11011, 32'd600);
        send_poll(5'b11011, 32'd649);          // one short of debounce
        send_poll(5'b11011, 32'd650);
        send_poll(5'b11011, 32'd651);
        send_poll(5'b11011, 32'd652);
        send_poll(5'b11111, 32'd700);
        send_poll(5'b10111, 32'd705);          // bounce
        send_poll(5'b11111, 32'd710);
        send_poll(5'b11111, 32'd760);          // tap then release
        send_poll(5'b11111, 32'd761);
        send_poll(5'b11101, 32'hFFFF_FFE0);
        send_poll(5'b11101, 32'h0000_0012);    // debounce across wrap
        send_poll(5'b00000, 32'h0000_0206);
        send_poll(5'b00000, 32'h0000_0207);
        send_poll(5'b00000, 32'hFFFF_FFFF);
        send_poll(5'b00000, 32'hFFFF_FFFF);
        send_poll(5'b11111, 32'hFFFF_FFFF);
        send_poll(5'b11111, 32'h0000_0031);
        send_poll(5'b11111, 32'h0000_0032);
        send_poll(5'b11111, 32'h0000_0033);
        finish_stream();
    endtask

    // Zero debounce accepts on the second poll; zero hold fires one ms later
    task automatic test_zero_debounce();
        program_timing(16'd0, 16'd0);
        send_poll(5'b11111, 32'd100);
        send_poll(5'b11110, 32'd100);
        send_poll(5'b11110, 32'd100);
        send_poll(5'b11110, 32'd101);
        send_poll(5'b11111, 32'd101);
        send_poll(5'b11111, 32'd101);
        send_poll(5'b11111, 32'd102);
        send_poll(5'b11111, 32'd102);
        finish_stream();
    endtask

    task automatic test_no_idling();
        run_random_polls(250, 16'd3, 16'd20, 8, $urandom, 0, 0);
    endtask

    task automatic test_sender_idle();
        run_random_polls(200, 16'd0, 16'd7, 4, $urandom, 71, 0);
    endtask

    task automatic test_receiver_stall();
        run_random_polls(150, 16'hFFFF, 16'hFFFF, 40000, $urandom, 0, 71);
    endtask

    task automatic test_both_idle();
        int deb;
        int hold;
        deb  = $urandom_range(1, 30);
        hold = $urandom_range(10, 200);
        run_random_polls(250, bged_pkg::CFG_WIDTH'(deb), bged_pkg::CFG_WIDTH'(hold),
                         hold / 4 + 2, $urandom, 10, 10);
    endtask

    // Consumer stops for a long stretch while polls keep coming; the earlier
    // stream is drained first so the hold-off lands on this one
    task automatic test_backpressure();
        program_timing(16'd5, 16'd40);
        hold_off_req <= hold_off_req + 1;
        run_random_polls(150, 16'd5, 16'd40, 12, $urandom, 0, 0);
    endtask

    task automatic test_counter_wrap();
        run_random_polls(250, 16'd20, 16'd100, 30, 32'hFFFF_F000, 10, 10);
    endtask

    initial
    begin
        settled_level = '1;
        seen_level    = '1;
        hold_armed    = '0;
        for (int b = 0; b < bged_pkg::NUM_BUTTONS; b++)
        begin
            change_ts[b]     = '0;
            press_ts[b]      = '0;
            pending_kinds[b] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_gestures();
        test_zero_debounce();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        test_counter_wrap();

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[button_gesture_event_detector_unit.f]
design/bged_pkg.sv
design/bged_cell.sv
design/button_gesture_event_detector_unit.sv
tb/testbench.sv
